### hw/rtl/bkesc_pkg.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared payload types, escape phase codes and the decoder result bundle.
// ----------------------------------------------------------------------------
package bkesc_pkg;

   // One escaped byte of the incoming string.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_last;
   } req_type;

   // One decoded byte leaving the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_type;

   // Where the decoder stands inside an escape sequence.
   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_ESC  = 2'd1,
      PH_HEX0 = 2'd2,
      PH_HEX1 = 2'd3
   } phase_type;

   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned PosWidth   = 2;

   // Everything the decoder produces for one request.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [CountWidth-1:0]      count;
      phase_type                  next_phase;
      logic [7:0]                 next_held;
   } dec_type;

endpackage

### hw/rtl/bkesc_decode.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder: single-request decode
// Works out the decoded bytes and the next escape state for one request.
// ----------------------------------------------------------------------------
module bkesc_decode (
   input  bkesc_pkg::req_type   item,
   input  bkesc_pkg::phase_type phase,
   input  logic [7:0]           held,
   input  logic [255:0]         extra_set,
   output bkesc_pkg::dec_type   dec
);

   localparam logic [7:0] ChBsl = 8'h5C;
   localparam logic [7:0] ChR   = 8'h72;
   localparam logic [7:0] ChN   = 8'h6E;
   localparam logic [7:0] ChT   = 8'h74;
   localparam logic [7:0] ChX   = 8'h78;
   localparam logic [7:0] ChCr  = 8'h0D;
   localparam logic [7:0] ChLf  = 8'h0A;
   localparam logic [7:0] ChTab = 8'h09;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   logic [7:0] b;
   logic       last;
   logic       opens;

   assign b     = item.in_byte;
   assign last  = item.string_last;
   // A backslash in ordinary text opens an escape unless it closes the string.
   assign opens = (b == ChBsl) && !last;

   always_comb begin
      dec            = '0;
      dec.next_phase = bkesc_pkg::PH_TEXT;
      dec.next_held  = held;
      unique case (phase)
         bkesc_pkg::PH_TEXT: begin
            if (opens) begin
               dec.next_phase = bkesc_pkg::PH_ESC;
            end else begin
               dec.bytes[0] = b;
               dec.count    = 3'd1;
            end
         end
         bkesc_pkg::PH_ESC: begin
            if (b == ChBsl) begin
               dec.bytes[0] = ChBsl;
               dec.count    = 3'd1;
            end else if (b == ChR) begin
               dec.bytes[0] = ChCr;
               dec.count    = 3'd1;
            end else if (b == ChN) begin
               dec.bytes[0] = ChLf;
               dec.count    = 3'd1;
            end else if (b == ChT) begin
               dec.bytes[0] = ChTab;
               dec.count    = 3'd1;
            end else if (b == ChX) begin
               if (last) begin
                  dec.bytes[0] = ChBsl;
                  dec.bytes[1] = ChX;
                  dec.count    = 3'd2;
               end else begin
                  dec.next_phase = bkesc_pkg::PH_HEX0;
               end
            end else if (extra_set[b]) begin
               dec.bytes[0] = b;
               dec.count    = 3'd1;
            end else begin
               dec.bytes[0] = ChBsl;
               dec.bytes[1] = b;
               dec.count    = 3'd2;
            end
         end
         bkesc_pkg::PH_HEX0: begin
            if (is_hex(b) && !last) begin
               dec.next_held  = b;
               dec.next_phase = bkesc_pkg::PH_HEX1;
            end else begin
               dec.bytes[0] = ChBsl;
               dec.bytes[1] = ChX;
               if (opens) begin
                  dec.count      = 3'd2;
                  dec.next_phase = bkesc_pkg::PH_ESC;
               end else begin
                  dec.bytes[2] = b;
                  dec.count    = 3'd3;
               end
            end
         end
         bkesc_pkg::PH_HEX1: begin
            if (is_hex(b)) begin
               dec.bytes[0] = {hex_val(held), hex_val(b)};
               dec.count    = 3'd1;
            end else begin
               dec.bytes[0] = ChBsl;
               dec.bytes[1] = ChX;
               dec.bytes[2] = held;
               if (opens) begin
                  dec.count      = 3'd3;
                  dec.next_phase = bkesc_pkg::PH_ESC;
               end else begin
                  dec.bytes[3] = b;
                  dec.count    = 3'd4;
               end
            end
         end
         default: begin
            dec.next_phase = bkesc_pkg::PH_TEXT;
         end
      endcase
      // The end of a string always returns the decoder to ordinary text.
      if (last) begin
         dec.next_phase = bkesc_pkg::PH_TEXT;
      end
   end

endmodule

### hw/rtl/backslash_escape_decoder.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Streaming C-style unescaper: one escaped byte in, zero to four bytes out.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel, one escaped byte per request with a
// flag on the final byte of each string. Decoded bytes leave on the rsp_
// channel, one per response; run_end marks the last response caused by a
// request and string_end the final response of a whole string.
// A request is held in an input register and is then decoded by a short
// block of logic into a result buffer of up to four bytes; the first response
// is offered once the buffer has taken the request, which waits while busy.
// The result buffer drains one byte per cycle while the receiver is ready:
// a request that yields n bytes leaves as n responses and one that yields
// none as none, so plain text sustains one request per cycle while ready.
// The input register is refilled while the buffer still holds bytes, so the
// sender is only held off when both the input register and the buffer are
// busy. When the receiver stalls, the current response is held unchanged.
// Reset is synchronous; it returns the decoder to ordinary text, empties both
// stages and clears the four 64-bit escape set registers written through the
// csr_ port (register i at byte address 8*i).
// ----------------------------------------------------------------------------
module backslash_escape_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bkesc_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bkesc_pkg::rsp_type  rsp_payload,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   // Configuration registers: the 256-bit set of bytes taken literally.
   logic [3:0][63:0] set_ff;
   logic [3:0][63:0] set_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = set_ff[csr_paddr[4:3]];

   always_comb begin
      set_in = set_ff;
      if (csr_write) begin
         set_in[csr_paddr[4:3]] = csr_pwdata;
      end
   end

   // Input register stage.
   bkesc_pkg::req_type in_ff;
   bkesc_pkg::req_type in_in;
   logic               in_valid_ff;
   logic               in_valid_in;

   // Escape state carried from one request to the next.
   bkesc_pkg::phase_type phase_ff;
   bkesc_pkg::phase_type phase_in;
   logic [7:0]           held_ff;
   logic [7:0]           held_in;

   // Result buffer: the decoded bytes of one request and a read position.
   logic [bkesc_pkg::MaxResults-1:0][7:0] bytes_ff;
   logic [bkesc_pkg::MaxResults-1:0][7:0] bytes_in;
   logic [bkesc_pkg::CountWidth-1:0]      count_ff;
   logic [bkesc_pkg::CountWidth-1:0]      count_in;
   logic [bkesc_pkg::PosWidth-1:0]        pos_ff;
   logic [bkesc_pkg::PosWidth-1:0]        pos_in;
   logic                                  last_ff;
   logic                                  last_in;
   logic                                  buf_valid_ff;
   logic                                  buf_valid_in;

   bkesc_pkg::dec_type dec;
   logic               run_end;
   logic               buf_free;
   logic               load;

   bkesc_decode u_decode (
      .item      (in_ff),
      .phase     (phase_ff),
      .held      (held_ff),
      .extra_set (set_ff),
      .dec       (dec)
   );

   // The response on offer is the last of its request when the read position
   // has reached the final decoded byte.
   assign run_end = ({1'b0, pos_ff} + 3'd1) == count_ff;

   // The buffer may take the next request when empty or as its last byte leaves.
   assign buf_free  = !buf_valid_ff || (rsp_ready && run_end);
   assign load      = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || load;

   assign rsp_valid              = buf_valid_ff;
   assign rsp_payload.out_byte   = bytes_ff[pos_ff];
   assign rsp_payload.run_end    = run_end;
   assign rsp_payload.string_end = run_end && last_ff;

   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      bytes_in     = bytes_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      buf_valid_in = buf_valid_ff;

      if (req_ready) begin
         in_in       = req_payload;
         in_valid_in = req_valid;
      end

      if (load) begin
         // A request that yields nothing only moves the escape state on.
         phase_in     = dec.next_phase;
         held_in      = dec.next_held;
         bytes_in     = dec.bytes;
         count_in     = dec.count;
         pos_in       = '0;
         last_in      = in_ff.string_last;
         buf_valid_in = dec.count != '0;
      end else if (buf_valid_ff && rsp_ready) begin
         if (run_end) begin
            buf_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff       <= '0;
         in_valid_ff  <= 1'b0;
         phase_ff     <= bkesc_pkg::PH_TEXT;
         held_ff      <= '0;
         buf_valid_ff <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
      end else begin
         set_ff       <= set_in;
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         buf_valid_ff <= buf_valid_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

endmodule
